@@ rtl/seek_steer_motion_step_top_defines.svh @@
// Assertion macros for the seek steering motion block.
`ifndef SEEK_STEER_MOTION_STEP_TOP_DEFINES_SVH
`define SEEK_STEER_MOTION_STEP_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SSM_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("seek steer motion check failed");
`define SSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("seek steer motion check failed");
`else
`define SSM_ASSERT_IMPLY(lbl, ante, cons)
`define SSM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/ssm_pkg.sv @@
// Shared types and constants of the seek steering motion block.
`default_nettype none
package ssm_pkg;

  localparam int VAL_W     = 32;
  localparam int TIME_W    = 16;
  localparam int LIM_W     = 31;
  localparam int FRAC_BITS = 16;
  localparam int SC_W      = 30;
  localparam int SUM_W     = 62;
  localparam int ROOT_W    = 31;
  localparam int PROD_W    = 63;
  localparam int DVD_W     = 61;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED = 8'd1;

  localparam logic [LIM_W-1:0] ACCEL_RESET = 31'd655360;
  localparam logic [LIM_W-1:0] SPEED_RESET = 31'd1966080;

  // Square of a Q16.16 distance of 0.001, held at Q32.32 scale, rounded up.
  localparam logic [SUM_W-1:0] DIST_EPS_SQ =
    SUM_W'((64'd1 << (2 * FRAC_BITS)) / 64'd1000000 + 64'd1);

  localparam logic [1:0] MUL_SQ     = 2'd0;
  localparam logic [1:0] MUL_SCALE  = 2'd1;
  localparam logic [1:0] MUL_DT_ACC = 2'd2;
  localparam logic [1:0] MUL_DT_VEL = 2'd3;

  typedef struct packed {
    logic       load_in;
    logic       place;
    logic       diff;
    logic       shrink;
    logic [1:0] mul_src;
    logic [1:0] mul_idx;
    logic       sum_clr;
    logic       sum_add;
    logic       sqrt_start;
    logic       use_speed;
    logic [2:0] div_start;
    logic       write_acc;
    logic       write_vclamp;
    logic       write_vkeep;
    logic       form_v;
    logic       pos_upd;
    logic [1:0] upd_idx;
    logic       out_load;
  } ssm_cmd_t;

  typedef struct packed {
    logic place;
    logic far;
    logic over;
    logic sqrt_done;
    logic div_done;
  } ssm_stat_t;

endpackage
`default_nettype wire

@@ rtl/ssm_isqrt.sv @@
// Bit-serial integer square root, two radicand bits per cycle.
`default_nettype none
module ssm_isqrt
  import ssm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SUM_W-1:0]  radicand,
  output logic                   done,
  output logic [ROOT_W-1:0]      root
);

  logic [SUM_W-1:0] x_r, x_nxt;
  logic [SUM_W-1:0] r_r, r_nxt;
  logic [SUM_W-1:0] b_r, b_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [SUM_W-1:0] rb;

  assign rb = r_r + b_r;

  always_comb begin
    x_nxt    = x_r;
    r_nxt    = r_r;
    b_nxt    = b_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = radicand;
      r_nxt    = '0;
      b_nxt    = SUM_W'(1) << (SUM_W - 2);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (x_r >= rb) begin
        x_nxt = x_r - rb;
        r_nxt = (r_r >> 1) + b_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      b_nxt = b_r >> 2;
      if (b_r == SUM_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt;
    r_r <= r_nxt;
    b_r <= b_nxt;
  end

  assign done = done_r;
  assign root = r_r[ROOT_W-1:0];

endmodule
`default_nettype wire

@@ rtl/ssm_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient known below 2^31.
`default_nettype none
module ssm_div
  import ssm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DVD_W-1:0]  dividend,
  input  wire logic [ROOT_W-1:0] divisor,
  output logic                   done,
  output logic [ROOT_W-1:0]      quot
);

  localparam int STEPS = DVD_W - SC_W;
  localparam int CNT_W = $clog2(STEPS);

  logic [ROOT_W-1:0] rem_r, rem_nxt;
  logic [STEPS-1:0]  low_r, low_nxt;
  logic [ROOT_W-1:0] quot_r, quot_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [ROOT_W:0]   trial;

  assign trial = {rem_r, low_r[STEPS-1]};

  always_comb begin
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // The high part is already below the divisor, so only the low bits remain.
      rem_nxt  = ROOT_W'(dividend[DVD_W-1:STEPS]);
      low_nxt  = dividend[STEPS-1:0];
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt  = ROOT_W'(trial - {1'b0, divisor});
        quot_nxt = {quot_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[ROOT_W-1:0];
        quot_nxt = {quot_r[ROOT_W-2:0], 1'b0};
      end
      low_nxt = low_r << 1;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    low_r  <= low_nxt;
    quot_r <= quot_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

@@ rtl/ssm_datapath.sv @@
// Datapath: motion state, shared multiplier, square root and divider lanes.
`default_nettype none
module ssm_datapath
  import ssm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ssm_cmd_t              cmd,
  output ssm_stat_t                  stat,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DAT_W-1:0]  cfg_data,
  input  wire logic [111:0]          in_tdata,
  input  wire logic [0:0]            in_tuser,
  output logic [319:0]               out_tdata,
  output logic [0:0]                 out_tuser
);

  localparam logic signed [33:0] MAXV = 34'sd2147483647;
  localparam logic signed [33:0] MINV = -34'sd2147483648;

  function automatic logic [VAL_W-1:0] sat34(input logic signed [33:0] x);
    logic [VAL_W-1:0] res;
    if (x > MAXV) res = MAXV[VAL_W-1:0];
    else if (x < MINV) res = MINV[VAL_W-1:0];
    else res = x[VAL_W-1:0];
    return res;
  endfunction

  function automatic logic [VAL_W-1:0] mag32(input logic [VAL_W-1:0] x);
    return x[VAL_W-1] ? (~x + VAL_W'(1)) : x;
  endfunction

  function automatic logic [VAL_W-1:0] apply_sign(input logic neg,
                                                  input logic [ROOT_W-1:0] q);
    logic [VAL_W-1:0] v;
    v = {1'b0, q};
    return neg ? (~v + VAL_W'(1)) : v;
  endfunction

  logic [VAL_W-1:0]  pos_r [3];
  logic [VAL_W-1:0]  vel_r [3];
  logic [VAL_W-1:0]  acc_r [3];
  logic [VAL_W-1:0]  coord_r [3];
  logic [TIME_W-1:0] dt_r;
  logic              place_r;
  logic [32:0]       vec_r [3];
  logic [SC_W-1:0]   sc_mag_r [3];
  logic [2:0]        sc_neg_r;
  logic [1:0]        shift_r;
  logic [SUM_W-1:0]  sum_r;
  logic [PROD_W-1:0] prod_r;
  logic [ROOT_W-1:0] len_r;
  logic [LIM_W-1:0]  accel_lim_r;
  logic [LIM_W-1:0]  speed_lim_r;
  logic [LIM_W-1:0]  speed_r;
  logic              clamped_r;
  logic [319:0]      out_data_r;
  logic              out_flag_r;

  // Shrink step: magnitudes, their maximum and the common shift.
  logic [32:0]       vmag [3];
  logic [32:0]       mmax;
  logic [1:0]        shift_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vmag[i] = vec_r[i][32] ? (~vec_r[i] + 33'd1) : vec_r[i];
    end
    mmax = vmag[0];
    if (vmag[1] > mmax) mmax = vmag[1];
    if (vmag[2] > mmax) mmax = vmag[2];
    if (mmax[32]) shift_nxt = 2'd3;
    else if (mmax[31]) shift_nxt = 2'd2;
    else if (mmax[30]) shift_nxt = 2'd1;
    else shift_nxt = 2'd0;
  end

  // Shared multiplier operand selection.
  logic [VAL_W-1:0]  mul_a;
  logic [LIM_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;

  always_comb begin
    case (cmd.mul_src)
      MUL_SQ: begin
        mul_a = VAL_W'(sc_mag_r[cmd.mul_idx]);
        mul_b = LIM_W'(sc_mag_r[cmd.mul_idx]);
      end
      MUL_SCALE: begin
        mul_a = VAL_W'(sc_mag_r[cmd.mul_idx]);
        mul_b = cmd.use_speed ? speed_lim_r : accel_lim_r;
      end
      MUL_DT_ACC: begin
        mul_a = mag32(acc_r[cmd.mul_idx]);
        mul_b = LIM_W'(dt_r);
      end
      MUL_DT_VEL: begin
        mul_a = mag32(vel_r[cmd.mul_idx]);
        mul_b = LIM_W'(dt_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Euler update term: a base value plus the signed time-step product.
  logic [VAL_W-1:0]  upd_base;
  logic              upd_neg;
  logic [33:0]       upd_q;
  logic signed [33:0] upd_sum;

  always_comb begin
    upd_base = cmd.form_v ? vel_r[cmd.upd_idx] : pos_r[cmd.upd_idx];
    upd_neg  = cmd.form_v ? acc_r[cmd.upd_idx][VAL_W-1] : vel_r[cmd.upd_idx][VAL_W-1];
    upd_q    = 34'(prod_r[TIME_W+VAL_W-1:TIME_W]);
    upd_sum  = $signed({{2{upd_base[VAL_W-1]}}, upd_base})
             + $signed(upd_neg ? (~upd_q + 34'd1) : upd_q);
  end

  logic [33:0] speed_full;
  assign speed_full = 34'(len_r) << shift_r;

  assign stat.place = place_r;
  assign stat.far   = (shift_r != 2'd0) || (sum_r >= DIST_EPS_SQ);
  assign stat.over  = speed_full > 34'(speed_lim_r);

  logic              sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;
  logic [2:0]        div_done;
  logic [ROOT_W-1:0] quot [3];

  ssm_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (sum_r),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    ssm_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (cmd.div_start[g]),
      .dividend (prod_r[DVD_W-1:0]),
      .divisor  (len_r),
      .done     (div_done[g]),
      .quot     (quot[g])
    );
  end

  assign stat.sqrt_done = sqrt_done;
  // Lane two starts last, so its finish means all three are done.
  assign stat.div_done  = div_done[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
        acc_r[i] <= '0;
      end
      accel_lim_r <= ACCEL_RESET;
      speed_lim_r <= SPEED_RESET;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_ACCEL) accel_lim_r <= cfg_data[LIM_W-1:0];
        else if (cfg_index == REG_SPEED) speed_lim_r <= cfg_data[LIM_W-1:0];
      end
      if (cmd.place) begin
        for (int i = 0; i < 3; i++) begin
          pos_r[i] <= coord_r[i];
          vel_r[i] <= '0;
          acc_r[i] <= '0;
        end
      end
      if (cmd.write_acc) begin
        for (int i = 0; i < 3; i++) acc_r[i] <= apply_sign(sc_neg_r[i], quot[i]);
      end
      if (cmd.write_vclamp) begin
        for (int i = 0; i < 3; i++) vel_r[i] <= apply_sign(sc_neg_r[i], quot[i]);
      end
      if (cmd.write_vkeep) begin
        for (int i = 0; i < 3; i++) vel_r[i] <= sat34($signed({vec_r[i][32], vec_r[i]}));
      end
      if (cmd.pos_upd) pos_r[cmd.upd_idx] <= sat34(upd_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      coord_r[0] <= in_tdata[31:0];
      coord_r[1] <= in_tdata[63:32];
      coord_r[2] <= in_tdata[95:64];
      dt_r       <= in_tdata[111:96];
      place_r    <= in_tuser[0];
    end
    if (cmd.diff) begin
      for (int i = 0; i < 3; i++) begin
        vec_r[i] <= {coord_r[i][VAL_W-1], coord_r[i]} - {pos_r[i][VAL_W-1], pos_r[i]};
      end
    end
    if (cmd.form_v) vec_r[cmd.upd_idx] <= upd_sum[32:0];
    if (cmd.shrink) begin
      for (int i = 0; i < 3; i++) begin
        sc_mag_r[i] <= SC_W'(vmag[i] >> shift_nxt);
        sc_neg_r[i] <= vec_r[i][32];
      end
      shift_r <= shift_nxt;
    end
    prod_r <= mul_p;
    if (cmd.sum_clr) sum_r <= '0;
    else if (cmd.sum_add) sum_r <= sum_r + prod_r[SUM_W-1:0];
    if (sqrt_done) len_r <= sqrt_root;
    if (cmd.place) begin
      speed_r   <= '0;
      clamped_r <= 1'b0;
    end else if (cmd.write_vclamp) begin
      speed_r   <= speed_lim_r;
      clamped_r <= 1'b1;
    end else if (cmd.write_vkeep) begin
      speed_r   <= speed_full[LIM_W-1:0];
      clamped_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data_r <= {1'b0, speed_r, acc_r[2], acc_r[1], acc_r[0],
                     vel_r[2], vel_r[1], vel_r[0], pos_r[2], pos_r[1], pos_r[0]};
      out_flag_r <= clamped_r;
    end
  end

  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_flag_r;

endmodule
`default_nettype wire

@@ rtl/ssm_ctrl.sv @@
// Sequencer that steps the datapath through one place or step word.
`default_nettype none
module ssm_ctrl
  import ssm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  input  wire ssm_stat_t stat,
  output ssm_cmd_t       cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd1;
  localparam logic [4:0] S_SHR  = 5'd2;
  localparam logic [4:0] S_SQ0  = 5'd3;
  localparam logic [4:0] S_SQ1  = 5'd4;
  localparam logic [4:0] S_SQ2  = 5'd5;
  localparam logic [4:0] S_SQA  = 5'd6;
  localparam logic [4:0] S_TEST = 5'd7;
  localparam logic [4:0] S_RTW  = 5'd8;
  localparam logic [4:0] S_CHK  = 5'd9;
  localparam logic [4:0] S_MS0  = 5'd10;
  localparam logic [4:0] S_MS1  = 5'd11;
  localparam logic [4:0] S_MS2  = 5'd12;
  localparam logic [4:0] S_MS3  = 5'd13;
  localparam logic [4:0] S_DIVW = 5'd14;
  localparam logic [4:0] S_WRQ  = 5'd15;
  localparam logic [4:0] S_DT0  = 5'd16;
  localparam logic [4:0] S_DT1  = 5'd17;
  localparam logic [4:0] S_DT2  = 5'd18;
  localparam logic [4:0] S_DT3  = 5'd19;
  localparam logic [4:0] S_DP0  = 5'd20;
  localparam logic [4:0] S_DP1  = 5'd21;
  localparam logic [4:0] S_DP2  = 5'd22;
  localparam logic [4:0] S_DP3  = 5'd23;
  localparam logic [4:0] S_OUT  = 5'd24;

  logic [4:0] state_r, state_nxt;
  logic       phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.use_speed = phase_r;
    case (state_r)
      S_IDLE: begin
        cmd.load_in = in_tvalid;
        if (in_tvalid) state_nxt = S_DISP;
      end
      S_DISP: begin
        if (stat.place) begin
          cmd.place = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.diff  = 1'b1;
          phase_nxt = 1'b0;
          state_nxt = S_SHR;
        end
      end
      S_SHR: begin
        cmd.shrink  = 1'b1;
        cmd.sum_clr = 1'b1;
        state_nxt   = S_SQ0;
      end
      S_SQ0: begin
        cmd.mul_src = MUL_SQ;
        cmd.mul_idx = 2'd0;
        state_nxt   = S_SQ1;
      end
      S_SQ1: begin
        cmd.mul_src = MUL_SQ;
        cmd.mul_idx = 2'd1;
        cmd.sum_add = 1'b1;
        state_nxt   = S_SQ2;
      end
      S_SQ2: begin
        cmd.mul_src = MUL_SQ;
        cmd.mul_idx = 2'd2;
        cmd.sum_add = 1'b1;
        state_nxt   = S_SQA;
      end
      S_SQA: begin
        cmd.sum_add = 1'b1;
        state_nxt   = S_TEST;
      end
      S_TEST: begin
        // A target this close keeps the previous acceleration.
        if (!phase_r && !stat.far) begin
          state_nxt = S_DT0;
        end else begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_RTW;
        end
      end
      S_RTW: begin
        if (stat.sqrt_done) state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!phase_r || stat.over) begin
          state_nxt = S_MS0;
        end else begin
          cmd.write_vkeep = 1'b1;
          state_nxt       = S_DP0;
        end
      end
      S_MS0: begin
        cmd.mul_src = MUL_SCALE;
        cmd.mul_idx = 2'd0;
        state_nxt   = S_MS1;
      end
      S_MS1: begin
        cmd.mul_src   = MUL_SCALE;
        cmd.mul_idx   = 2'd1;
        cmd.div_start = 3'b001;
        state_nxt     = S_MS2;
      end
      S_MS2: begin
        cmd.mul_src   = MUL_SCALE;
        cmd.mul_idx   = 2'd2;
        cmd.div_start = 3'b010;
        state_nxt     = S_MS3;
      end
      S_MS3: begin
        cmd.div_start = 3'b100;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (stat.div_done) state_nxt = S_WRQ;
      end
      S_WRQ: begin
        if (!phase_r) begin
          cmd.write_acc = 1'b1;
          state_nxt     = S_DT0;
        end else begin
          cmd.write_vclamp = 1'b1;
          state_nxt        = S_DP0;
        end
      end
      S_DT0: begin
        cmd.mul_src = MUL_DT_ACC;
        cmd.mul_idx = 2'd0;
        state_nxt   = S_DT1;
      end
      S_DT1: begin
        cmd.mul_src = MUL_DT_ACC;
        cmd.mul_idx = 2'd1;
        cmd.form_v  = 1'b1;
        cmd.upd_idx = 2'd0;
        state_nxt   = S_DT2;
      end
      S_DT2: begin
        cmd.mul_src = MUL_DT_ACC;
        cmd.mul_idx = 2'd2;
        cmd.form_v  = 1'b1;
        cmd.upd_idx = 2'd1;
        state_nxt   = S_DT3;
      end
      S_DT3: begin
        cmd.form_v  = 1'b1;
        cmd.upd_idx = 2'd2;
        phase_nxt   = 1'b1;
        state_nxt   = S_SHR;
      end
      S_DP0: begin
        cmd.mul_src = MUL_DT_VEL;
        cmd.mul_idx = 2'd0;
        state_nxt   = S_DP1;
      end
      S_DP1: begin
        cmd.mul_src = MUL_DT_VEL;
        cmd.mul_idx = 2'd1;
        cmd.pos_upd = 1'b1;
        cmd.upd_idx = 2'd0;
        state_nxt   = S_DP2;
      end
      S_DP2: begin
        cmd.mul_src = MUL_DT_VEL;
        cmd.mul_idx = 2'd2;
        cmd.pos_upd = 1'b1;
        cmd.upd_idx = 2'd1;
        state_nxt   = S_DP3;
      end
      S_DP3: begin
        cmd.pos_upd = 1'b1;
        cmd.upd_idx = 2'd2;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        // Wait until the output register is free or drains this cycle.
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

@@ rtl/seek_steer_motion_step_top.sv @@
// A place word is loaded, then placed, then loaded into the output register.
// A step word always takes a square root pass for the new velocity; a far target adds
// a root and a scaling pass for the acceleration, a clamped speed a scaling pass.
// The next word is taken in the cycle after the result is loaded, and a waiting
// result stalls only the next load.
// Reset (rst_n low, synchronous) clears position, velocity and acceleration
// and restores the acceleration limit to 10.0 and the speed limit to 30.0.
`default_nettype none
`include "seek_steer_motion_step_top_defines.svh"
module seek_steer_motion_step_top
  import ssm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // coord_x, coord_y, coord_z, time_step
  input  wire logic [111:0]         in_tdata,
  // operation
  input  wire logic [0:0]           in_tuser,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, speed_now
  output logic [319:0]              out_tdata,
  // speed_clamped
  output logic [0:0]                out_tuser,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  ssm_cmd_t  cmd;
  ssm_stat_t stat;

  assign cfg_ready = rst_n;

  ssm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ssm_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Only one word is in work at a time.
  `SSM_ASSERT_NEXT(a_one_in_work, in_tvalid && in_tready, !in_tready)
  // A fresh result appears exactly as the sequencer returns to idle.
  `SSM_ASSERT_IMPLY(a_result_at_idle, $rose(out_tvalid), in_tready)

endmodule
`default_nettype wire
